[sv/jss_pkg.sv]
// Shared types and constants of the joint setpoint shaper.
package jss_pkg;

  localparam int JOINTS = 4;
  localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int ANGLE_W = 16;
  localparam int CFG_W = 20;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LP_WEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_RATE = 3'd4;

  localparam angle_t MIN_ANGLE_RST = -16'sd16384;
  localparam angle_t MAX_ANGLE_RST = 16'sd16384;
  localparam logic [15:0] LP_WEIGHT_RST = 16'd6554;
  localparam logic [19:0] MAX_RATE_RST = 20'd16384;
  localparam logic [19:0] STARTUP_RATE_RST = 20'd32768;

  localparam logic [15:0] ALPHA_ONE = 16'd32768;
  localparam logic [16:0] PROGRESS_ONE = 17'd65536;
  localparam logic [17:0] SMOOTH_THREE = 18'd196608;

endpackage

[sv/joint_setpoint_shaper_top.sv]
// Four-joint setpoint shaper: smoothstep startup, low-pass filter and rate limit.
// One shared signed multiplier runs under a small sequencer; the block takes one tick at a time.
// Startup ticks step through CHK, P1, PP, S and a J step per joint, later ticks through CHK, LIM and an F
// step per joint. An e-stop result is valid next cycle; the next tick is taken in the cycle after the result transfer.
// Synchronous active-high reset restores the register defaults, zeroes the joint state and
// disarms the block, so the next tick latches the measured pose.
module joint_setpoint_shaper_top
  import jss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   target_angle_0,
  input  logic signed [15:0]   target_angle_1,
  input  logic signed [15:0]   target_angle_2,
  input  logic signed [15:0]   target_angle_3,
  input  logic signed [15:0]   measured_angle_0,
  input  logic signed [15:0]   measured_angle_1,
  input  logic signed [15:0]   measured_angle_2,
  input  logic signed [15:0]   measured_angle_3,
  input  logic [15:0]          tick_dt,
  input  logic                 e_stop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_angle_0,
  output logic signed [15:0]   out_angle_1,
  output logic signed [15:0]   out_angle_2,
  output logic signed [15:0]   out_angle_3,
  output logic                 in_startup
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_CHKD = 4'd2;
  localparam logic [3:0] S_P1   = 4'd3;
  localparam logic [3:0] S_P2   = 4'd4;
  localparam logic [3:0] S_PP   = 4'd5;
  localparam logic [3:0] S_S    = 4'd6;
  localparam logic [3:0] S_SS   = 4'd7;
  localparam logic [3:0] S_J    = 4'd8;
  localparam logic [3:0] S_JW   = 4'd9;
  localparam logic [3:0] S_LIM  = 4'd10;
  localparam logic [3:0] S_LIMW = 4'd11;
  localparam logic [3:0] S_F    = 4'd12;
  localparam logic [3:0] S_FW   = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0] state;
  logic [JIDX_W-1:0] jidx;
  logic armed;
  logic startup_flag;

  angle_t min_angle;
  angle_t max_angle;
  logic [15:0] lp_weight;
  logic [19:0] max_rate;
  logic [19:0] startup_rate;

  angle_t prev_angle [JOINTS];
  angle_t start_angle [JOINTS];
  angle_t tgt [JOINTS];
  logic [31:0] elapsed;
  logic [15:0] dt_r;
  logic [16:0] p_r;
  logic [16:0] s_r;
  logic [19:0] lim_r;

  logic signed [33:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [54:0] mul_q;

  angle_t tgt_in [JOINTS];
  angle_t meas_in [JOINTS];
  angle_t tgt_clamp [JOINTS];

  logic accept;
  logic last_joint;
  logic signed [16:0] diff_start;
  logic signed [16:0] diff_prev;
  logic [15:0] alpha_eff;
  logic [17:0] smooth_k;
  logic [35:0] prog_hi;
  logic [32:0] elapsed_sum;
  logic signed [54:0] ramp_rnd;
  logic signed [54:0] filt_rnd;
  logic signed [21:0] delta;
  logic signed [21:0] lim_s;
  logic signed [21:0] delta_c;

  assign tgt_in[0] = target_angle_0;
  assign tgt_in[1] = target_angle_1;
  assign tgt_in[2] = target_angle_2;
  assign tgt_in[3] = target_angle_3;
  assign meas_in[0] = measured_angle_0;
  assign meas_in[1] = measured_angle_1;
  assign meas_in[2] = measured_angle_2;
  assign meas_in[3] = measured_angle_3;

  always_comb begin
    for (int i = 0; i < JOINTS; i++) begin
      tgt_clamp[i] = (tgt_in[i] > max_angle) ? max_angle : tgt_in[i];
      if (tgt_clamp[i] < min_angle) begin
        tgt_clamp[i] = min_angle;
      end
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);
  assign last_joint = (jidx == JIDX_W'(JOINTS - 1));

  assign out_angle_0 = prev_angle[0];
  assign out_angle_1 = prev_angle[1];
  assign out_angle_2 = prev_angle[2];
  assign out_angle_3 = prev_angle[3];
  assign in_startup = startup_flag;

  assign diff_start = {tgt[jidx][15], tgt[jidx]} - {start_angle[jidx][15], start_angle[jidx]};
  assign diff_prev = {tgt[jidx][15], tgt[jidx]} - {prev_angle[jidx][15], prev_angle[jidx]};
  assign alpha_eff = (lp_weight > ALPHA_ONE) ? ALPHA_ONE : lp_weight;
  assign smooth_k = SMOOTH_THREE - {p_r, 1'b0};
  assign prog_hi = mul_q[51:16];
  assign elapsed_sum = {1'b0, elapsed} + {17'd0, dt_r};
  assign ramp_rnd = (mul_q + 55'sd32768) >>> 16;
  assign filt_rnd = (mul_q + 55'sd16384) >>> 15;
  assign delta = filt_rnd[21:0];
  assign lim_s = signed'({2'b00, lim_r});

  always_comb begin
    delta_c = delta;
    if (delta > lim_s) begin
      delta_c = lim_s;
    end else if (delta < -lim_s) begin
      delta_c = -lim_s;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CHK, S_P1: begin
        mul_a = signed'({2'b00, elapsed});
        mul_b = signed'({1'b0, startup_rate});
      end
      S_PP: begin
        mul_a = signed'({17'd0, p_r});
        mul_b = signed'({4'd0, p_r});
      end
      S_S: begin
        mul_a = signed'({1'b0, mul_q[32:0]});
        mul_b = signed'({3'd0, smooth_k});
      end
      S_J: begin
        mul_a = 34'(diff_start);
        mul_b = signed'({4'd0, s_r});
      end
      S_LIM: begin
        mul_a = signed'({18'd0, dt_r});
        mul_b = signed'({1'b0, max_rate});
      end
      S_F: begin
        mul_a = 34'(diff_prev);
        mul_b = signed'({5'd0, alpha_eff});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_angle <= MIN_ANGLE_RST;
      max_angle <= MAX_ANGLE_RST;
      lp_weight <= LP_WEIGHT_RST;
      max_rate <= MAX_RATE_RST;
      startup_rate <= STARTUP_RATE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIN_ANGLE: min_angle <= cfg_data[15:0];
        REG_MAX_ANGLE: max_angle <= cfg_data[15:0];
        REG_LP_WEIGHT: lp_weight <= cfg_data[15:0];
        REG_MAX_RATE: max_rate <= cfg_data;
        REG_STARTUP_RATE: startup_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      jidx <= '0;
      armed <= 1'b0;
      startup_flag <= 1'b0;
      elapsed <= '0;
      for (int i = 0; i < JOINTS; i++) begin
        prev_angle[i] <= '0;
        start_angle[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            dt_r <= tick_dt;
            for (int i = 0; i < JOINTS; i++) begin
              tgt[i] <= tgt_clamp[i];
            end
            if (e_stop) begin
              armed <= 1'b0;
              startup_flag <= 1'b0;
              for (int i = 0; i < JOINTS; i++) begin
                prev_angle[i] <= meas_in[i];
              end
              state <= S_OUT;
            end else begin
              if (!armed) begin
                for (int i = 0; i < JOINTS; i++) begin
                  prev_angle[i] <= meas_in[i];
                  start_angle[i] <= meas_in[i];
                end
                elapsed <= '0;
                armed <= 1'b1;
              end
              state <= S_CHK;
            end
          end
        end
        S_CHK: state <= S_CHKD;
        S_CHKD: begin
          if (mul_q[51:32] == 20'd0) begin
            elapsed <= elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
            startup_flag <= 1'b1;
            state <= S_P1;
          end else begin
            startup_flag <= 1'b0;
            state <= S_LIM;
          end
        end
        S_P1: state <= S_P2;
        S_P2: begin
          p_r <= (prog_hi > 36'(PROGRESS_ONE)) ? PROGRESS_ONE : prog_hi[16:0];
          state <= S_PP;
        end
        S_PP: state <= S_S;
        S_S: state <= S_SS;
        S_SS: begin
          s_r <= mul_q[48:32];
          jidx <= '0;
          state <= S_J;
        end
        S_J: state <= S_JW;
        S_JW: begin
          prev_angle[jidx] <= start_angle[jidx] + ramp_rnd[15:0];
          jidx <= jidx + 1'b1;
          state <= last_joint ? S_OUT : S_J;
        end
        S_LIM: state <= S_LIMW;
        S_LIMW: begin
          lim_r <= mul_q[35:16];
          jidx <= '0;
          state <= S_F;
        end
        S_F: state <= S_FW;
        S_FW: begin
          prev_angle[jidx] <= prev_angle[jidx] + delta_c[15:0];
          jidx <= jidx + 1'b1;
          state <= last_joint ? S_OUT : S_F;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/jss_checker.sv]
// Port-level checker of the joint setpoint shaper and its bind.
module jss_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic signed [15:0]   measured_angle_0,
  input logic signed [15:0]   measured_angle_3,
  input logic                 e_stop,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic signed [15:0]   out_angle_0,
  input logic signed [15:0]   out_angle_1,
  input logic signed [15:0]   out_angle_2,
  input logic signed [15:0]   out_angle_3,
  input logic                 in_startup
);

  // A pending result blocks new input transfers.
  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  // An emergency stop echoes the measured angles of joints 0 and 3 on the next cycle, outside startup.
  a_estop_echo: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && e_stop) |=>
      (out_valid && !in_startup && out_angle_0 == $past(measured_angle_0)
       && out_angle_3 == $past(measured_angle_3)))
    else $error("emergency stop result does not echo measured angles");

  // A transferred result is not repeated: out_valid drops right after the result transfer.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result repeated");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_angle_0) && $stable(out_angle_1)
       && $stable(out_angle_2) && $stable(out_angle_3) && $stable(in_startup)))
    else $error("stalled result changed");

endmodule

bind joint_setpoint_shaper_top jss_checker u_jss_checker (.*);
